// ===== rtl/core/tacho_period_filter_rpm_top_defines.svh =====
// Assertion macros used by the tachometer period filter checker.
`ifndef TACHO_PERIOD_FILTER_RPM_TOP_DEFINES_SVH
`define TACHO_PERIOD_FILTER_RPM_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TPF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/tpf_pkg.sv =====
// Shared types and constants of the tachometer period filter.
`timescale 1ns / 1ps
package tpf_pkg;

   localparam int MAX_SAMPLES  = 16;
   localparam int NUM_CHANNELS = 3;
   localparam int IDX_W        = $clog2(MAX_SAMPLES);
   localparam int WIN_W        = IDX_W + 1;
   localparam int PERIOD_W     = 16;
   localparam int SUM_W        = PERIOD_W + IDX_W;
   localparam int CNT_W        = IDX_W + 1;
   localparam int RPM_W        = 26;
   localparam int SPOKE_W      = 8;
   localparam int DEN_W        = SPOKE_W + PERIOD_W;
   localparam int RING_DEPTH   = NUM_CHANNELS * MAX_SAMPLES;
   localparam int RING_AW      = $clog2(RING_DEPTH);
   localparam int CSR_AW       = 5;
   localparam int CSR_DW       = 32;

   localparam logic [RPM_W-1:0] RPM_NUMERATOR = RPM_W'(60000000);

   localparam logic [1:0] CH_FLY     = 2'd2;
   localparam logic [1:0] CH_ILLEGAL = 2'd3;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ILLEGAL  = 2'd1,
      STATUS_ZERO_SUM = 2'd2,
      STATUS_NO_BAND  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      REG_DRIVE_WINDOW = 3'd0,
      REG_FLY_WINDOW   = 3'd1,
      REG_DRIVE_BAND   = 3'd2,
      REG_FLY_BAND     = 3'd3,
      REG_DRIVE_SPOKES = 3'd4,
      REG_FLY_SPOKES   = 3'd5,
      REG_SPARE_6      = 3'd6,
      REG_SPARE_7      = 3'd7
   } reg_index_type;

endpackage

// ===== rtl/core/tpf_req_if.sv =====
// Request channel interface of the tachometer period filter.
`timescale 1ns / 1ps
interface tpf_req_if import tpf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          channel;
   logic [PERIOD_W-1:0] new_period;
   logic [PERIOD_W-1:0] elapsed_ticks;

   modport source (output valid, channel, new_period, elapsed_ticks, input ready);
   modport sink (input valid, channel, new_period, elapsed_ticks, output ready);
endinterface

// ===== rtl/core/tpf_rsp_if.sv =====
// Response channel interface of the tachometer period filter.
`timescale 1ns / 1ps
interface tpf_rsp_if import tpf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [RPM_W-1:0]    rpm_scaled;
   logic [PERIOD_W-1:0] period_estimate;
   logic [1:0]          status;

   modport source (output valid, rpm_scaled, period_estimate, status, input ready);
   modport sink (input valid, rpm_scaled, period_estimate, status, output ready);
endinterface

// ===== rtl/core/tpf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module tpf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/tacho_period_filter_rpm_top.sv =====
// Top level of the tachometer period filter with period to rpm conversion.
`timescale 1ns / 1ps
// Each request names an encoder channel and carries its newest pulse period and the ticks
// elapsed since the last pulse; the period is stored in that channel's ring, the ring entries
// within the band of the newest are summed and averaged, and the result is the period estimate
// and rpm_scaled = 60000000 / (spokes * estimate) with a status. One transaction is processed
// at a time. A legal request passes an accept state, walks the ring through the RAM read port in
// the walk and last states, passes a check state, the shared bit-serial divider for the mean, a
// multiply state, the divider again for the rpm and a done state that loads the response register
// once it is free. When the elapsed ticks replace the mean the mean division is skipped; a zero
// in-band sum finishes right after the check, an illegal channel straight after the accept. A
// finished response waits in its own register, so the next request is accepted while it is
// still unread. Configuration registers sit at byte address 4 * index on the APB port.
module tacho_period_filter_rpm_top import tpf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   tpf_req_if.sink           req_chan,
   tpf_rsp_if.source         rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   localparam int EST_SHIFT = RPM_W - SUM_W;
   localparam int STEP_W    = $clog2(RPM_W + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_LAST,
      S_CHECK,
      S_DIV_EST,
      S_MUL,
      S_DIV_RPM,
      S_DONE
   } state_type;

   // Configuration registers.
   logic [WIN_W-1:0]    drive_window_ff, fly_window_ff;
   logic [PERIOD_W-1:0] drive_band_ff, fly_band_ff;
   logic [SPOKE_W-1:0]  drive_spokes_ff, fly_spokes_ff;
   logic                csr_we;
   reg_index_type       csr_idx;

   // Engine registers.
   state_type           state_ff, state_in;
   logic [1:0]          ch_ff, ch_in;
   logic [PERIOD_W-1:0] newest_ff, newest_in;
   logic [PERIOD_W-1:0] elapsed_ff, elapsed_in;
   logic [WIN_W-1:0]    window_ff, window_in;
   logic [PERIOD_W-1:0] band_ff, band_in;
   logic [SPOKE_W-1:0]  spokes_ff, spokes_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                pend_ff, pend_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PERIOD_W-1:0] est_ff, est_in;
   logic [RPM_W-1:0]    rpm_ff, rpm_in;
   status_type          status_ff, status_in;
   logic [RPM_W-1:0]    q_ff, q_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [IDX_W-1:0]    ptr_ff [NUM_CHANNELS];
   logic [IDX_W-1:0]    ptr_in [NUM_CHANNELS];
   logic [RING_DEPTH-1:0] vld_ff, vld_in;
   logic                rd_ok_ff, rd_ok_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RPM_W-1:0]    rsp_rpm_ff, rsp_rpm_in;
   logic [PERIOD_W-1:0] rsp_est_ff, rsp_est_in;
   status_type          rsp_status_ff, rsp_status_in;

   // Ring RAM ports.
   logic                ram_we;
   logic [RING_AW-1:0]  ram_waddr, ram_raddr;
   logic [PERIOD_W-1:0] ram_rdata;

   // Helper signals.
   logic                accept;
   logic [WIN_W-1:0]    win_raw, win_clamped;
   logic [IDX_W-1:0]    ptr_cur, ptr_wr;
   logic [WIN_W-1:0]    ptr_inc;
   logic [PERIOD_W-1:0] ring_val, diff;
   logic [SUM_W:0]      sum_band;
   logic [DEN_W:0]      dv_r, dv_diff;
   logic                dv_ge;
   logic [DEN_W-1:0]    rem_step;
   logic [RPM_W-1:0]    q_step;
   logic [DEN_W-1:0]    prod;

   tpf_ram #(
      .WIDTH (PERIOD_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_chan.new_period),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // APB configuration port.
   assign pready  = 1'b1;
   assign csr_idx = reg_index_type'(paddr[CSR_AW-1:2]);
   assign csr_we  = psel && penable && pwrite && pready;

   always_comb begin
      prdata = '0;
      unique case (csr_idx)
         REG_DRIVE_WINDOW: prdata = CSR_DW'(drive_window_ff);
         REG_FLY_WINDOW:   prdata = CSR_DW'(fly_window_ff);
         REG_DRIVE_BAND:   prdata = CSR_DW'(drive_band_ff);
         REG_FLY_BAND:     prdata = CSR_DW'(fly_band_ff);
         REG_DRIVE_SPOKES: prdata = CSR_DW'(drive_spokes_ff);
         REG_FLY_SPOKES:   prdata = CSR_DW'(fly_spokes_ff);
         REG_SPARE_6:      prdata = '0;
         REG_SPARE_7:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_window_ff <= WIN_W'(8);
         fly_window_ff   <= WIN_W'(8);
         drive_band_ff   <= PERIOD_W'(100);
         fly_band_ff     <= PERIOD_W'(100);
         drive_spokes_ff <= SPOKE_W'(8);
         fly_spokes_ff   <= SPOKE_W'(8);
      end else if (csr_we) begin
         unique case (csr_idx)
            REG_DRIVE_WINDOW: drive_window_ff <= pwdata[WIN_W-1:0];
            REG_FLY_WINDOW:   fly_window_ff   <= pwdata[WIN_W-1:0];
            REG_DRIVE_BAND:   drive_band_ff   <= pwdata[PERIOD_W-1:0];
            REG_FLY_BAND:     fly_band_ff     <= pwdata[PERIOD_W-1:0];
            REG_DRIVE_SPOKES: drive_spokes_ff <= pwdata[SPOKE_W-1:0];
            REG_FLY_SPOKES:   fly_spokes_ff   <= pwdata[SPOKE_W-1:0];
            REG_SPARE_6:      ;
            REG_SPARE_7:      ;
         endcase
      end
   end

   // Handshake.
   assign req_chan.ready           = (state_ff == S_IDLE);
   assign accept                   = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.rpm_scaled      = rsp_rpm_ff;
   assign rsp_chan.period_estimate = rsp_est_ff;
   assign rsp_chan.status          = rsp_status_ff;

   // Window, pointer and ring write for an incoming request.
   always_comb begin
      win_raw = (req_chan.channel == CH_FLY) ? fly_window_ff : drive_window_ff;
      if (win_raw == '0) begin
         win_clamped = WIN_W'(1);
      end else if (win_raw > WIN_W'(MAX_SAMPLES)) begin
         win_clamped = WIN_W'(MAX_SAMPLES);
      end else begin
         win_clamped = win_raw;
      end
      ptr_cur = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if (req_chan.channel == 2'(c)) begin
            ptr_cur = ptr_ff[c];
         end
      end
      ptr_wr    = ({1'b0, ptr_cur} >= win_clamped) ? '0 : ptr_cur;
      ptr_inc   = {1'b0, ptr_wr} + WIN_W'(1);
      ram_we    = accept && (req_chan.channel != CH_ILLEGAL);
      ram_waddr = RING_AW'(req_chan.channel) * RING_AW'(MAX_SAMPLES) + RING_AW'(ptr_wr);
      ram_raddr = RING_AW'(ch_ff) * RING_AW'(MAX_SAMPLES) + RING_AW'(idx_ff);
   end

   // In-band test on the entry read back from the ring.
   always_comb begin
      ring_val = rd_ok_ff ? ram_rdata : '0;
      diff     = (ring_val >= newest_ff) ? ring_val - newest_ff : newest_ff - ring_val;
      sum_band = {1'b0, sum_ff} + (SUM_W + 1)'(band_ff);
   end

   // Shared restoring divider, one quotient bit per cycle.
   always_comb begin
      dv_r     = {rem_ff, q_ff[RPM_W-1]};
      dv_diff  = dv_r - {1'b0, den_ff};
      dv_ge    = (dv_r >= {1'b0, den_ff});
      rem_step = dv_ge ? dv_diff[DEN_W-1:0] : dv_r[DEN_W-1:0];
      q_step   = {q_ff[RPM_W-2:0], dv_ge};
      prod     = DEN_W'(spokes_ff) * DEN_W'(est_ff);
   end

   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      newest_in     = newest_ff;
      elapsed_in    = elapsed_ff;
      window_in     = window_ff;
      band_in       = band_ff;
      spokes_in     = spokes_ff;
      idx_in        = idx_ff;
      pend_in       = 1'b0;
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      est_in        = est_ff;
      rpm_in        = rpm_ff;
      status_in     = status_ff;
      q_in          = q_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      step_in       = step_ff;
      ptr_in        = ptr_ff;
      vld_in        = vld_ff;
      rd_ok_in      = vld_ff[ram_raddr];
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_rpm_in    = rsp_rpm_ff;
      rsp_est_in    = rsp_est_ff;
      rsp_status_in = rsp_status_ff;

      if (pend_ff) begin
         if (diff <= band_ff) begin
            sum_in = sum_ff + SUM_W'(ring_val);
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ch_in      = req_chan.channel;
               newest_in  = req_chan.new_period;
               elapsed_in = req_chan.elapsed_ticks;
               window_in  = win_clamped;
               idx_in     = '0;
               sum_in     = '0;
               cnt_in     = '0;
               if (req_chan.channel == CH_FLY) begin
                  band_in   = fly_band_ff;
                  spokes_in = (fly_spokes_ff == '0) ? SPOKE_W'(1) : fly_spokes_ff;
               end else begin
                  band_in   = drive_band_ff;
                  spokes_in = (drive_spokes_ff == '0) ? SPOKE_W'(1) : drive_spokes_ff;
               end
               if (req_chan.channel == CH_ILLEGAL) begin
                  rpm_in    = '0;
                  est_in    = '0;
                  status_in = STATUS_ILLEGAL;
                  state_in  = S_DONE;
               end else begin
                  vld_in[ram_waddr] = 1'b1;
                  ptr_in[req_chan.channel] = (ptr_inc >= win_clamped) ? '0
                                                                     : ptr_inc[IDX_W-1:0];
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            pend_in = 1'b1;
            idx_in  = idx_ff + IDX_W'(1);
            if ({1'b0, idx_ff} == window_ff - WIN_W'(1)) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            rpm_in    = '0;
            est_in    = '0;
            status_in = STATUS_OK;
            if (sum_ff == '0) begin
               status_in = STATUS_ZERO_SUM;
               state_in  = S_DONE;
            end else if (cnt_ff == '0) begin
               status_in = STATUS_NO_BAND;
               state_in  = S_DONE;
            end else if (sum_band < (SUM_W + 1)'(elapsed_ff)) begin
               est_in   = elapsed_ff;
               state_in = S_MUL;
            end else begin
               q_in     = {sum_ff, {EST_SHIFT{1'b0}}};
               rem_in   = '0;
               den_in   = DEN_W'(cnt_ff);
               step_in  = STEP_W'(SUM_W);
               state_in = S_DIV_EST;
            end
         end
         S_DIV_EST: begin
            q_in    = q_step;
            rem_in  = rem_step;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               est_in   = q_step[PERIOD_W-1:0];
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (est_ff == '0) begin
               rpm_in   = '0;
               state_in = S_DONE;
            end else begin
               den_in   = prod;
               q_in     = RPM_NUMERATOR;
               rem_in   = '0;
               step_in  = STEP_W'(RPM_W);
               state_in = S_DIV_RPM;
            end
         end
         S_DIV_RPM: begin
            q_in    = q_step;
            rem_in  = rem_step;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               rpm_in   = q_step;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_rpm_in    = rpm_ff;
               rsp_est_in    = est_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ch_ff         <= ch_in;
      newest_ff     <= newest_in;
      elapsed_ff    <= elapsed_in;
      window_ff     <= window_in;
      band_ff       <= band_in;
      spokes_ff     <= spokes_in;
      idx_ff        <= idx_in;
      sum_ff        <= sum_in;
      cnt_ff        <= cnt_in;
      est_ff        <= est_in;
      rpm_ff        <= rpm_in;
      status_ff     <= status_in;
      q_ff          <= q_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      step_ff       <= step_in;
      rd_ok_ff      <= rd_ok_in;
      rsp_rpm_ff    <= rsp_rpm_in;
      rsp_est_ff    <= rsp_est_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            ptr_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
      end
   end

endmodule

// ===== rtl/core/tpf_checker.sv =====
// Port-level checker of the tachometer period filter and its bind to the top level.
`timescale 1ns / 1ps
`include "tacho_period_filter_rpm_top_defines.svh"
module tpf_checker import tpf_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [RPM_W-1:0]    rsp_rpm_scaled,
   input logic [PERIOD_W-1:0] rsp_period_estimate,
   input logic [1:0]          rsp_status
);

   `TPF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_rpm_scaled) && $stable(rsp_period_estimate) && $stable(rsp_status), "Stalled response transaction changed.")
   `TPF_ASSERT_SAME(a_err_zero, clock, reset, rsp_valid && (rsp_status != STATUS_OK), (rsp_rpm_scaled == '0) && (rsp_period_estimate == '0), "Error response carries nonzero data.")
   `TPF_ASSERT_SAME(a_rpm_needs_period, clock, reset, rsp_valid && (rsp_rpm_scaled != '0), rsp_period_estimate != '0, "Nonzero rpm with a zero period estimate.")
   `TPF_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "Request accepted while a transaction is in progress.")

endmodule

bind tacho_period_filter_rpm_top tpf_checker u_tpf_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_rpm_scaled      (rsp_chan.rpm_scaled),
   .rsp_period_estimate (rsp_chan.period_estimate),
   .rsp_status          (rsp_chan.status)
);
